// ===== hdl/iesa_pkg.sv =====
// Shared types, codes and reset values for the input event snapshot arbiter.
// No dependencies; the front, back and top-level files of the block refer to this package.
package iesa_pkg;

  // Default geometry of the sample store.
  localparam int CONTROL_COUNT_DEF = 256;
  localparam int DEVICE_SLOTS_DEF  = 4;

  // Depth of the decoupling queues.
  localparam int QUEUE_DEPTH = 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MOUSE     = 1'b1;

  // Command codes.
  localparam logic [1:0] CMD_SEED    = 2'd0;
  localparam logic [1:0] CMD_EVENT   = 2'd1;
  localparam logic [1:0] CMD_RESOLVE = 2'd2;

  // Event kinds.
  localparam logic [2:0] EV_PRESS   = 3'd0;
  localparam logic [2:0] EV_RELEASE = 3'd1;
  localparam logic [2:0] EV_ABS     = 3'd2;
  localparam logic [2:0] EV_REL     = 3'd3;
  localparam logic [2:0] EV_EXIT    = 3'd4;

  // Value kinds.
  localparam logic [2:0] VK_NONE    = 3'd0;
  localparam logic [2:0] VK_DIGITAL = 3'd1;
  localparam logic [2:0] VK_REL     = 3'd2;
  localparam logic [2:0] VK_PULSE   = 3'd3;
  localparam logic [2:0] VK_ABS     = 3'd4;

  // Activity ranks.
  localparam logic [1:0] RANK_NONE   = 2'd0;
  localparam logic [1:0] RANK_AXIS   = 2'd1;
  localparam logic [1:0] RANK_MOMENT = 2'd2;

  // Q16.16 constants and saturation limits.
  localparam logic signed [31:0] Q_ONE   = 32'sh0001_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

  // Reset values.
  localparam logic [31:0] THRESH_RST   = 32'd16384;
  localparam logic [3:0]  MOUSE_RST    = 4'd2;
  localparam logic [3:0]  DEV_KEYBOARD = 4'd1;
  localparam logic [3:0]  PLAT_DESKTOP = 4'd1;

  // One entry of the sample store.
  typedef struct packed {
    logic               down;
    logic               pressed;
    logic               released;
    logic               present;
    logic signed [31:0] value;
  } entry_t;

  // A classified item as it travels from the front to the back.
  typedef struct packed {
    logic [1:0]         cmd;
    logic               addr_ok;
    logic [2:0]         ekind;
    logic [2:0]         vkind;
    logic signed [31:0] value;
    logic               seed_present;
    logic               seed_down;
    logic [3:0]         dclass;
    logic [3:0]         plat;
    logic [1:0]         rec_rank;
  } item_t;

  // One result word.
  typedef struct packed {
    entry_t     entry;
    logic [3:0] active_device;
    logic [3:0] active_platform;
    logic [1:0] frame_rank;
    logic       frame_conflict;
  } result_t;

  // Sequencer states of the back part.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } back_state_t;

endpackage

// ===== hdl/iesa_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module iesa_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/iesa_fifo.sv =====
// Small register queue with push/full and pop/empty sides.
// No dependencies; used for the command queue and the result queue.
module iesa_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  // Pointer and fill level updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage holds payload only.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== hdl/iesa_front.sv =====
// Front part: accepts input words, checks the address, ranks the activity
// and queues the classified word. Depends on iesa_pkg and iesa_fifo.
module iesa_front #(
  parameter int CONTROL_COUNT = iesa_pkg::CONTROL_COUNT_DEF,
  parameter int DEVICE_SLOTS  = iesa_pkg::DEVICE_SLOTS_DEF,
  localparam int AW = $clog2(CONTROL_COUNT * DEVICE_SLOTS),
  localparam int QW = AW + $bits(iesa_pkg::item_t)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         in_cmd,
  input  logic [7:0]         in_control_index,
  input  logic [1:0]         in_device_slot,
  input  logic [2:0]         in_event_kind,
  input  logic signed [31:0] in_event_value,
  input  logic [2:0]         in_value_kind,
  input  logic [3:0]         in_device_class,
  input  logic [3:0]         in_platform_code,
  input  logic               in_seed_present,
  input  logic               in_seed_down,
  input  logic [31:0]        threshold,
  input  logic [3:0]         mouse_class,
  input  logic               clearing,
  input  logic               q_pop,
  output logic               q_empty,
  output logic [QW-1:0]      q_word
);

  iesa_pkg::item_t item;
  logic [AW-1:0]   addr;
  logic            q_full;
  logic            press;
  logic [31:0]     mag_val;
  logic [31:0]     mag_act;
  logic [1:0]      rank;

  // Magnitude of a signed Q16.16 value; the most negative value maps to 2^31.
  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // Nothing is taken while the store is being cleared.
  assign full = q_full || clearing;

  // Flat entry address and range check.
  assign addr = AW'(in_control_index) * AW'(DEVICE_SLOTS) + AW'(in_device_slot);

  // Activity ranking of an event.
  assign press   = (in_event_kind == iesa_pkg::EV_PRESS);
  assign mag_val = mag32(in_event_value);
  assign mag_act = press ? iesa_pkg::Q_ONE : mag_val;

  always_comb begin
    case (in_value_kind)
      iesa_pkg::VK_DIGITAL: rank = press ? iesa_pkg::RANK_MOMENT : iesa_pkg::RANK_NONE;
      iesa_pkg::VK_REL: begin
        rank = ((in_device_class != mouse_class) && (in_event_value != '0)) ?
               iesa_pkg::RANK_MOMENT : iesa_pkg::RANK_NONE;
      end
      iesa_pkg::VK_PULSE: begin
        rank = (in_event_value != '0) ? iesa_pkg::RANK_MOMENT : iesa_pkg::RANK_NONE;
      end
      iesa_pkg::VK_ABS: rank = (mag_val > threshold) ? iesa_pkg::RANK_AXIS : iesa_pkg::RANK_NONE;
      default: rank = iesa_pkg::RANK_NONE;
    endcase
  end

  // Build the classified word; the rank is kept only where it is recorded.
  always_comb begin
    item.cmd          = in_cmd;
    item.addr_ok      = (32'(in_control_index) < 32'(CONTROL_COUNT)) &&
                        (32'(in_device_slot) < 32'(DEVICE_SLOTS));
    item.ekind        = in_event_kind;
    item.vkind        = in_value_kind;
    item.value        = in_event_value;
    item.seed_present = in_seed_present;
    item.seed_down    = in_seed_down;
    item.dclass       = in_device_class;
    item.plat         = in_platform_code;
    item.rec_rank     = iesa_pkg::RANK_NONE;
    if ((in_cmd == iesa_pkg::CMD_EVENT) && item.addr_ok && (in_device_class != 4'd0) &&
        (mag_act > threshold)) begin
      item.rec_rank = rank;
    end
  end

  // Command queue towards the back part.
  iesa_fifo #(
    .WIDTH(QW),
    .DEPTH(iesa_pkg::QUEUE_DEPTH)
  ) u_cmd_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push && !clearing),
    .wdata({addr, item}),
    .full (q_full),
    .pop  (q_pop),
    .rdata(q_word),
    .empty(q_empty)
  );

endmodule

// ===== hdl/iesa_back.sv =====
// Back part: clears the sample store after reset, then carries out each
// queued word as a read-modify-write and keeps the frame record.
// Depends on iesa_pkg, iesa_ram and iesa_fifo.
module iesa_back #(
  parameter int CONTROL_COUNT = iesa_pkg::CONTROL_COUNT_DEF,
  parameter int DEVICE_SLOTS  = iesa_pkg::DEVICE_SLOTS_DEF,
  localparam int DEPTH = CONTROL_COUNT * DEVICE_SLOTS,
  localparam int AW    = $clog2(DEPTH),
  localparam int IW    = $bits(iesa_pkg::item_t),
  localparam int QW    = AW + IW,
  localparam int RW    = $bits(iesa_pkg::result_t)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  logic [QW-1:0] q_word,
  output logic          q_pop,
  output logic          clearing,
  input  logic          res_pop,
  output logic          res_empty,
  output logic [RW-1:0] res_word
);

  localparam int EW = $bits(iesa_pkg::entry_t);

  iesa_pkg::back_state_t state_r, state_nxt;
  logic [AW-1:0]     clr_cnt_r, clr_cnt_nxt;
  iesa_pkg::item_t   item_r;
  logic [AW-1:0]     addr_r;
  logic              start;

  // Frame record and chosen source.
  logic [3:0] frame_dev_r, frame_dev_nxt;
  logic [3:0] frame_plat_r, frame_plat_nxt;
  logic [1:0] frame_prio_r, frame_prio_nxt;
  logic       frame_clash_r, frame_clash_nxt;
  logic [3:0] cur_dev_r, cur_dev_nxt;
  logic [3:0] cur_plat_r, cur_plat_nxt;

  // Store access.
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [EW-1:0]   ram_wdata;
  logic [EW-1:0]   ram_rdata;
  iesa_pkg::entry_t cur_entry;
  iesa_pkg::entry_t new_entry;
  logic            exec_we;
  logic [32:0]     sum;

  // Result queue.
  iesa_pkg::result_t res;
  logic              res_push;
  logic              res_full;

  assign start = !q_empty && !res_full;

  // Next state.
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      iesa_pkg::ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          state_nxt = iesa_pkg::ST_IDLE;
        end
      end
      iesa_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = iesa_pkg::ST_EXEC;
        end
      end
      iesa_pkg::ST_EXEC: state_nxt = iesa_pkg::ST_IDLE;
      default: state_nxt = iesa_pkg::ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= iesa_pkg::ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // Latch the word whose entry is being read.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      addr_r <= q_word[QW-1:IW];
      item_r <= iesa_pkg::item_t'(q_word[IW-1:0]);
    end
  end

  // Entry update for the word in execution.
  assign cur_entry = item_r.addr_ok ? iesa_pkg::entry_t'(ram_rdata) : '0;
  assign sum = {cur_entry.value[31], cur_entry.value} + {item_r.value[31], item_r.value};

  always_comb begin
    new_entry = cur_entry;
    exec_we   = 1'b0;
    case (item_r.cmd)
      iesa_pkg::CMD_SEED: begin
        exec_we   = item_r.addr_ok;
        new_entry = '0;
        if (item_r.vkind != iesa_pkg::VK_NONE) begin
          new_entry.present = item_r.seed_present;
        end
        if (item_r.vkind == iesa_pkg::VK_DIGITAL) begin
          new_entry.down  = item_r.seed_down;
          new_entry.value = item_r.value;
        end else if (item_r.vkind == iesa_pkg::VK_ABS) begin
          new_entry.value = item_r.value;
        end
      end
      iesa_pkg::CMD_EVENT: begin
        exec_we = item_r.addr_ok;
        case (item_r.ekind)
          iesa_pkg::EV_PRESS: begin
            new_entry.down    = 1'b1;
            new_entry.pressed = 1'b1;
            new_entry.value   = item_r.value;
          end
          iesa_pkg::EV_RELEASE: begin
            new_entry.down     = 1'b0;
            new_entry.released = 1'b1;
            new_entry.value    = '0;
          end
          iesa_pkg::EV_ABS: new_entry.value = item_r.value;
          iesa_pkg::EV_REL: begin
            // Saturate when the two top bits of the sum disagree.
            if (sum[32] != sum[31]) begin
              new_entry.value = sum[32] ? iesa_pkg::VAL_MIN : iesa_pkg::VAL_MAX;
            end else begin
              new_entry.value = sum[31:0];
            end
          end
          iesa_pkg::EV_EXIT: begin
            new_entry.down    = 1'b1;
            new_entry.pressed = 1'b1;
            new_entry.value   = iesa_pkg::Q_ONE;
          end
          default: new_entry = cur_entry;
        endcase
      end
      default: new_entry = cur_entry;
    endcase
  end

  // Frame record: ranking of events and adoption on resolve.
  always_comb begin
    frame_dev_nxt   = frame_dev_r;
    frame_plat_nxt  = frame_plat_r;
    frame_prio_nxt  = frame_prio_r;
    frame_clash_nxt = frame_clash_r;
    cur_dev_nxt     = cur_dev_r;
    cur_plat_nxt    = cur_plat_r;
    if (state_r == iesa_pkg::ST_EXEC) begin
      if ((item_r.cmd == iesa_pkg::CMD_EVENT) && (item_r.rec_rank != iesa_pkg::RANK_NONE)) begin
        if (item_r.rec_rank > frame_prio_r) begin
          frame_dev_nxt   = item_r.dclass;
          frame_plat_nxt  = item_r.plat;
          frame_prio_nxt  = item_r.rec_rank;
          frame_clash_nxt = 1'b0;
        end else if ((item_r.rec_rank == frame_prio_r) &&
                     ((frame_dev_r != item_r.dclass) || (frame_plat_r != item_r.plat))) begin
          frame_clash_nxt = 1'b1;
        end
      end else if ((item_r.cmd == iesa_pkg::CMD_RESOLVE) &&
                   (frame_prio_r != iesa_pkg::RANK_NONE)) begin
        if (!frame_clash_r) begin
          cur_dev_nxt  = frame_dev_r;
          cur_plat_nxt = frame_plat_r;
        end
        frame_dev_nxt   = '0;
        frame_plat_nxt  = '0;
        frame_prio_nxt  = iesa_pkg::RANK_NONE;
        frame_clash_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_dev_r   <= '0;
      frame_plat_r  <= '0;
      frame_prio_r  <= iesa_pkg::RANK_NONE;
      frame_clash_r <= 1'b0;
      cur_dev_r     <= iesa_pkg::DEV_KEYBOARD;
      cur_plat_r    <= iesa_pkg::PLAT_DESKTOP;
    end else begin
      frame_dev_r   <= frame_dev_nxt;
      frame_plat_r  <= frame_plat_nxt;
      frame_prio_r  <= frame_prio_nxt;
      frame_clash_r <= frame_clash_nxt;
      cur_dev_r     <= cur_dev_nxt;
      cur_plat_r    <= cur_plat_nxt;
    end
  end

  // Outputs of the sequencer: queue pop, store write and result push.
  always_comb begin
    q_pop     = 1'b0;
    clearing  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = new_entry;
    res_push  = 1'b0;
    case (state_r)
      iesa_pkg::ST_CLEAR: begin
        clearing  = 1'b1;
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = '0;
      end
      iesa_pkg::ST_IDLE: q_pop = start;
      iesa_pkg::ST_EXEC: begin
        ram_we   = exec_we;
        res_push = 1'b1;
      end
      default: clearing = 1'b1;
    endcase
  end

  // Result word reports the state after the step.
  always_comb begin
    res.entry           = item_r.addr_ok ? new_entry : '0;
    res.active_device   = cur_dev_nxt;
    res.active_platform = cur_plat_nxt;
    res.frame_rank      = frame_prio_nxt;
    res.frame_conflict  = frame_clash_nxt;
  end

  iesa_ram #(
    .WIDTH(EW),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(q_word[QW-1:IW]),
    .rdata(ram_rdata)
  );

  iesa_fifo #(
    .WIDTH(RW),
    .DEPTH(iesa_pkg::QUEUE_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_push),
    .wdata(res),
    .full (res_full),
    .pop  (res_pop),
    .rdata(res_word),
    .empty(res_empty)
  );

`ifndef SYNTHESIS
  // A word is only started when its result is sure to find room.
  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into a full result queue");

  // A conflict is only ever recorded against a ranked frame.
  a_clash_rank: assert property (@(posedge clk) disable iff (!rst_n)
    frame_clash_r |-> (frame_prio_r != iesa_pkg::RANK_NONE))
    else $error("frame conflict without frame rank");

  // A resolve always leaves the frame record empty.
  a_resolve_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == iesa_pkg::ST_EXEC) && (item_r.cmd == iesa_pkg::CMD_RESOLVE)) |=>
    ((frame_prio_r == iesa_pkg::RANK_NONE) && !frame_clash_r))
    else $error("frame record not cleared by resolve");

  // No word leaves the command queue while the store is being cleared.
  a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == iesa_pkg::ST_CLEAR) |-> !q_pop)
    else $error("command taken during clearing pass");
`endif

endmodule

// ===== hdl/input_event_snapshot_arbiter_top.sv =====
// Top level of the input event snapshot arbiter: configuration registers,
// front and back parts. Depends on iesa_pkg, iesa_front and iesa_back.
//
// After reset the block sweeps its sample store to zero, one entry a cycle,
// over all CONTROL_COUNT * DEVICE_SLOTS entries (1024 with the defaults),
// while full stays high; configuration writes are taken throughout. Each word
// then has its store entry read, then written back with its result posted,
// since the store has one write port and a registered read; the next word
// starts only after that. A two-word queue on each side lets pushes and pops
// proceed independently of that work; a result waits in the output queue
// until popped. Configuration must only be written while no word is in flight.
module input_event_snapshot_arbiter_top #(
  parameter int CONTROL_COUNT = iesa_pkg::CONTROL_COUNT_DEF,
  parameter int DEVICE_SLOTS  = iesa_pkg::DEVICE_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration write port.
  input  logic                            cfg_we,
  input  logic [iesa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [iesa_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // Input side.
  input  logic                            push,
  output logic                            full,
  input  logic [1:0]                      in_cmd,
  input  logic [7:0]                      in_control_index,
  input  logic [1:0]                      in_device_slot,
  input  logic [2:0]                      in_event_kind,
  input  logic signed [31:0]              in_event_value,
  input  logic [2:0]                      in_value_kind,
  input  logic [3:0]                      in_device_class,
  input  logic [3:0]                      in_platform_code,
  input  logic                            in_seed_present,
  input  logic                            in_seed_down,
  // Result side.
  output logic                            empty,
  input  logic                            pop,
  output logic                            out_is_down,
  output logic                            out_was_pressed,
  output logic                            out_was_released,
  output logic                            out_is_present,
  output logic signed [31:0]              out_entry_value,
  output logic [3:0]                      out_active_device,
  output logic [3:0]                      out_active_platform,
  output logic [1:0]                      out_frame_rank,
  output logic                            out_frame_conflict
);

  localparam int AW = $clog2(CONTROL_COUNT * DEVICE_SLOTS);
  localparam int QW = AW + $bits(iesa_pkg::item_t);
  localparam int RW = $bits(iesa_pkg::result_t);

  logic [31:0]       thresh_r, thresh_nxt;
  logic [3:0]        mouse_r, mouse_nxt;
  logic              clearing;
  logic              q_pop;
  logic              q_empty;
  logic [QW-1:0]     q_word;
  logic [RW-1:0]     res_word;
  iesa_pkg::result_t res;

  // Configuration register writes.
  always_comb begin
    thresh_nxt = thresh_r;
    mouse_nxt  = mouse_r;
    if (cfg_we) begin
      case (cfg_index)
        iesa_pkg::CFG_THRESHOLD: thresh_nxt = cfg_wdata;
        iesa_pkg::CFG_MOUSE:     mouse_nxt  = cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= iesa_pkg::THRESH_RST;
      mouse_r  <= iesa_pkg::MOUSE_RST;
    end else begin
      thresh_r <= thresh_nxt;
      mouse_r  <= mouse_nxt;
    end
  end

  iesa_front #(
    .CONTROL_COUNT(CONTROL_COUNT),
    .DEVICE_SLOTS (DEVICE_SLOTS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_cmd          (in_cmd),
    .in_control_index(in_control_index),
    .in_device_slot  (in_device_slot),
    .in_event_kind   (in_event_kind),
    .in_event_value  (in_event_value),
    .in_value_kind   (in_value_kind),
    .in_device_class (in_device_class),
    .in_platform_code(in_platform_code),
    .in_seed_present (in_seed_present),
    .in_seed_down    (in_seed_down),
    .threshold       (thresh_r),
    .mouse_class     (mouse_r),
    .clearing        (clearing),
    .q_pop           (q_pop),
    .q_empty         (q_empty),
    .q_word          (q_word)
  );

  iesa_back #(
    .CONTROL_COUNT(CONTROL_COUNT),
    .DEVICE_SLOTS (DEVICE_SLOTS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_word   (q_word),
    .q_pop    (q_pop),
    .clearing (clearing),
    .res_pop  (pop),
    .res_empty(empty),
    .res_word (res_word)
  );

  // Unpack the oldest result onto the ports.
  assign res                 = iesa_pkg::result_t'(res_word);
  assign out_is_down         = res.entry.down;
  assign out_was_pressed     = res.entry.pressed;
  assign out_was_released    = res.entry.released;
  assign out_is_present      = res.entry.present;
  assign out_entry_value     = res.entry.value;
  assign out_active_device   = res.active_device;
  assign out_active_platform = res.active_platform;
  assign out_frame_rank      = res.frame_rank;
  assign out_frame_conflict  = res.frame_conflict;

endmodule

// ===== test/iesa_result_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the input event snapshot arbiter: watches the input, result and
// configuration ports, predicts every result word and compares it on arrival.
// Depends on iesa_pkg for the codes, the register indexes and the result layout.
module iesa_result_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [iesa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [iesa_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            push,
  input  logic                            full,
  input  logic [1:0]                      in_cmd,
  input  logic [7:0]                      in_control_index,
  input  logic [1:0]                      in_device_slot,
  input  logic [2:0]                      in_event_kind,
  input  logic signed [31:0]              in_event_value,
  input  logic [2:0]                      in_value_kind,
  input  logic [3:0]                      in_device_class,
  input  logic [3:0]                      in_platform_code,
  input  logic                            in_seed_present,
  input  logic                            in_seed_down,
  input  logic                            empty,
  input  logic                            pop,
  input  logic                            out_is_down,
  input  logic                            out_was_pressed,
  input  logic                            out_was_released,
  input  logic                            out_is_present,
  input  logic signed [31:0]              out_entry_value,
  input  logic [3:0]                      out_active_device,
  input  logic [3:0]                      out_active_platform,
  input  logic [1:0]                      out_frame_rank,
  input  logic                            out_frame_conflict,
  output int                              mismatches,
  output int                              outstanding
);
  import iesa_pkg::*;

  localparam int         STORE_DEPTH = CONTROL_COUNT_DEF * DEVICE_SLOTS_DEF;
  localparam logic [3:0] CLASS_NONE  = 4'd0;

  // Own copy of the block's state and registers.
  entry_t      snapshot_mem [STORE_DEPTH];
  logic [3:0]  lead_device;
  logic [3:0]  lead_platform;
  logic [1:0]  lead_rank;
  logic        lead_clash;
  logic [3:0]  chosen_device;
  logic [3:0]  chosen_platform;
  logic [31:0] threshold_q;
  logic [3:0]  mouse_code;

  // Result words still to come, oldest first.
  result_t     due_results [$];
  result_t     fresh;
  result_t     head;
  int          results_seen;

  // Magnitude of a Q16.16 value; the most negative value gives 2^31.
  function automatic logic [32:0] magnitude_q(input logic signed [31:0] v);
    longint wide;
    wide = v;
    if (wide < 0) wide = -wide;
    return wide[32:0];
  endfunction

  // Applies one word to the state copy and works out the result word it causes.
  task automatic step_snapshot(
    input  logic [1:0]         cmd,
    input  logic [7:0]         ctl,
    input  logic [1:0]         slot,
    input  logic [2:0]         ekind,
    input  logic signed [31:0] val,
    input  logic [2:0]         vkind,
    input  logic [3:0]         dclass,
    input  logic [3:0]         plat,
    input  logic               spres,
    input  logic               sdown,
    output result_t            r
  );
    int                 idx;
    entry_t             e;
    logic               press;
    logic [1:0]         rank;
    logic signed [31:0] act;
    longint             sum;
    idx   = int'(ctl) * DEVICE_SLOTS_DEF + int'(slot);
    e     = snapshot_mem[idx];
    press = (ekind == EV_PRESS);
    rank  = RANK_NONE;
    case (cmd)
      CMD_SEED: begin
        e = '0;
        if (vkind != VK_NONE) begin
          e.present = spres;
          if (vkind == VK_DIGITAL) begin
            e.down  = sdown;
            e.value = val;
          end else if (vkind == VK_ABS) begin
            e.value = val;
          end
        end
        snapshot_mem[idx] = e;
      end
      CMD_EVENT: begin
        case (ekind)
          EV_PRESS: begin
            e.down    = 1'b1;
            e.pressed = 1'b1;
            e.value   = val;
          end
          EV_RELEASE: begin
            e.down     = 1'b0;
            e.released = 1'b1;
            e.value    = '0;
          end
          EV_ABS: e.value = val;
          EV_REL: begin
            // Relative motion accumulates and saturates at the signed limits.
            sum = longint'(e.value) + longint'(val);
            if (sum > longint'(VAL_MAX)) e.value = VAL_MAX;
            else if (sum < longint'(VAL_MIN)) e.value = VAL_MIN;
            else e.value = sum[31:0];
          end
          EV_EXIT: begin
            e.down    = 1'b1;
            e.pressed = 1'b1;
            e.value   = Q_ONE;
          end
          default: ;
        endcase
        snapshot_mem[idx] = e;

        // Rank the activity, then let it compete for the frame.
        case (vkind)
          VK_DIGITAL: rank = press ? RANK_MOMENT : RANK_NONE;
          VK_REL:     rank = (dclass != mouse_code && val != 0) ? RANK_MOMENT : RANK_NONE;
          VK_PULSE:   rank = (val != 0) ? RANK_MOMENT : RANK_NONE;
          VK_ABS:     rank = (magnitude_q(val) > {1'b0, threshold_q}) ? RANK_AXIS : RANK_NONE;
          default:    rank = RANK_NONE;
        endcase
        act = press ? Q_ONE : val;
        if (rank != RANK_NONE && dclass != CLASS_NONE &&
            magnitude_q(act) > {1'b0, threshold_q}) begin
          if (rank > lead_rank) begin
            lead_device   = dclass;
            lead_platform = plat;
            lead_rank     = rank;
            lead_clash    = 1'b0;
          end else if (rank == lead_rank &&
                       (lead_device != dclass || lead_platform != plat)) begin
            lead_clash = 1'b1;
          end
        end
      end
      CMD_RESOLVE: begin
        // A clean winner is adopted; the frame record is cleared either way.
        if (lead_rank != RANK_NONE) begin
          if (!lead_clash) begin
            chosen_device   = lead_device;
            chosen_platform = lead_platform;
          end
          lead_device   = '0;
          lead_platform = '0;
          lead_rank     = RANK_NONE;
          lead_clash    = 1'b0;
        end
      end
      default: ;
    endcase
    r.entry           = e;
    r.active_device   = chosen_device;
    r.active_platform = chosen_platform;
    r.frame_rank      = lead_rank;
    r.frame_conflict  = lead_clash;
  endtask

  // Counts a differing field and reports the first few.
  task automatic report_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result word %0d, %s: expected %0h, got %0h", results_seen, field,
                 want, got);
    end
  endtask

  // Everything is sampled at the rising edge, as the block sees it.
  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (snapshot_mem[i]) snapshot_mem[i] = '0;
      lead_device     = '0;
      lead_platform   = '0;
      lead_rank       = RANK_NONE;
      lead_clash      = 1'b0;
      chosen_device   = DEV_KEYBOARD;
      chosen_platform = PLAT_DESKTOP;
      threshold_q     = THRESH_RST;
      mouse_code      = MOUSE_RST;
      mismatches      = 0;
      results_seen    = 0;
      due_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_THRESHOLD) threshold_q = cfg_wdata;
        else if (cfg_index == CFG_MOUSE) mouse_code = cfg_wdata[3:0];
      end

      if (push && !full) begin
        step_snapshot(in_cmd, in_control_index, in_device_slot, in_event_kind,
                      in_event_value, in_value_kind, in_device_class, in_platform_code,
                      in_seed_present, in_seed_down, fresh);
        due_results.push_back(fresh);
      end

      if (pop && !empty) begin
        results_seen++;
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result word %0d arrived with nothing expected", results_seen);
        end else begin
          head = due_results.pop_front();
          report_field("is_down", 32'(head.entry.down), 32'(out_is_down));
          report_field("was_pressed", 32'(head.entry.pressed), 32'(out_was_pressed));
          report_field("was_released", 32'(head.entry.released), 32'(out_was_released));
          report_field("is_present", 32'(head.entry.present), 32'(out_is_present));
          report_field("entry_value", head.entry.value, out_entry_value);
          report_field("active_device", 32'(head.active_device), 32'(out_active_device));
          report_field("active_platform", 32'(head.active_platform),
                       32'(out_active_platform));
          report_field("frame_rank", 32'(head.frame_rank), 32'(out_frame_rank));
          report_field("frame_conflict", 32'(head.frame_conflict),
                       32'(out_frame_conflict));
        end
      end
    end
    outstanding = due_results.size();
  end

endmodule

// ===== test/input_event_snapshot_arbiter_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the input event snapshot arbiter: clock, reset, stimulus
// and verdict. Depends on iesa_pkg, the block's top level and iesa_result_checker.
module input_event_snapshot_arbiter_top_tb;
  import iesa_pkg::*;

  localparam int         CYCLE_LIMIT  = 400000;
  localparam int         PHASE_WORDS  = 100;
  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam logic [2:0] EV_UNKNOWN   = 3'd6;
  localparam logic [2:0] VK_UNKNOWN   = 3'd7;

  // One input word as the sender sees it.
  typedef struct packed {
    logic [1:0]         cmd;
    logic [7:0]         ctl;
    logic [1:0]         slot;
    logic [2:0]         ek;
    logic signed [31:0] val;
    logic [2:0]         vk;
    logic [3:0]         dc;
    logic [3:0]         plat;
    logic               sp;
    logic               sd;
  } event_word_t;

  logic                  clk              = 1'b0;
  logic                  rst_n            = 1'b0;
  logic                  cfg_we           = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index        = CFG_THRESHOLD;
  logic [CFG_DATA_W-1:0] cfg_wdata        = '0;
  logic                  push             = 1'b0;
  logic                  full;
  logic [1:0]            in_cmd           = CMD_SEED;
  logic [7:0]            in_control_index = '0;
  logic [1:0]            in_device_slot   = '0;
  logic [2:0]            in_event_kind    = EV_PRESS;
  logic signed [31:0]    in_event_value   = '0;
  logic [2:0]            in_value_kind    = VK_NONE;
  logic [3:0]            in_device_class  = '0;
  logic [3:0]            in_platform_code = '0;
  logic                  in_seed_present  = 1'b0;
  logic                  in_seed_down     = 1'b0;
  logic                  empty;
  logic                  pop              = 1'b0;
  logic                  out_is_down;
  logic                  out_was_pressed;
  logic                  out_was_released;
  logic                  out_is_present;
  logic signed [31:0]    out_entry_value;
  logic [3:0]            out_active_device;
  logic [3:0]            out_active_platform;
  logic [1:0]            out_frame_rank;
  logic                  out_frame_conflict;

  int          mismatches;
  int          outstanding;
  int          words_sent    = 0;
  int          cycle_count   = 0;
  int          pop_hold      = 0;
  logic        steady        = 1'b0;
  logic        sender_quiet  = 1'b0;
  logic        receiver_calm = 1'b0;
  logic [31:0] thresh_now    = THRESH_RST;
  logic [3:0]  mouse_now     = MOUSE_RST;

  always #10 clk = ~clk;

  input_event_snapshot_arbiter_top u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .push                (push),
    .full                (full),
    .in_cmd              (in_cmd),
    .in_control_index    (in_control_index),
    .in_device_slot      (in_device_slot),
    .in_event_kind       (in_event_kind),
    .in_event_value      (in_event_value),
    .in_value_kind       (in_value_kind),
    .in_device_class     (in_device_class),
    .in_platform_code    (in_platform_code),
    .in_seed_present     (in_seed_present),
    .in_seed_down        (in_seed_down),
    .empty               (empty),
    .pop                 (pop),
    .out_is_down         (out_is_down),
    .out_was_pressed     (out_was_pressed),
    .out_was_released    (out_was_released),
    .out_is_present      (out_is_present),
    .out_entry_value     (out_entry_value),
    .out_active_device   (out_active_device),
    .out_active_platform (out_active_platform),
    .out_frame_rank      (out_frame_rank),
    .out_frame_conflict  (out_frame_conflict)
  );

  iesa_result_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .push                (push),
    .full                (full),
    .in_cmd              (in_cmd),
    .in_control_index    (in_control_index),
    .in_device_slot      (in_device_slot),
    .in_event_kind       (in_event_kind),
    .in_event_value      (in_event_value),
    .in_value_kind       (in_value_kind),
    .in_device_class     (in_device_class),
    .in_platform_code    (in_platform_code),
    .in_seed_present     (in_seed_present),
    .in_seed_down        (in_seed_down),
    .empty               (empty),
    .pop                 (pop),
    .out_is_down         (out_is_down),
    .out_was_pressed     (out_was_pressed),
    .out_was_released    (out_was_released),
    .out_is_present      (out_is_present),
    .out_entry_value     (out_entry_value),
    .out_active_device   (out_active_device),
    .out_active_platform (out_active_platform),
    .out_frame_rank      (out_frame_rank),
    .out_frame_conflict  (out_frame_conflict),
    .mismatches          (mismatches),
    .outstanding         (outstanding)
  );

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: pops by default, with random stall bursts except in the steady phase or a calm spell.
  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) receiver_calm = !receiver_calm;
    if (!steady && !receiver_calm && pop_hold == 0 && $urandom_range(0, 5) == 0)
      pop_hold = $urandom_range(1, 9);
    if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold--;
    end else begin
      pop <= 1'b1;
    end
  end

  function automatic event_word_t mk(
    input logic [1:0] cmd, input logic [7:0] ctl, input logic [1:0] slot,
    input logic [2:0] ek, input logic signed [31:0] val, input logic [2:0] vk,
    input logic [3:0] dc, input logic [3:0] plat, input logic sp, input logic sd
  );
    return '{cmd, ctl, slot, ek, val, vk, dc, plat, sp, sd};
  endfunction

  // Every field random across its full width.
  function automatic event_word_t noise_word();
    return event_word_t'(60'({$urandom, $urandom}));
  endfunction

  // Mostly a handful of controls so that entries are revisited.
  function automatic logic [7:0] pick_control();
    return ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
  endfunction

  function automatic logic [2:0] pick_ekind();
    int r;
    r = $urandom_range(0, 15);
    if (r < 3) return EV_PRESS;
    if (r < 5) return EV_RELEASE;
    if (r < 8) return EV_ABS;
    if (r < 12) return EV_REL;
    if (r < 14) return EV_EXIT;
    return 3'($urandom);
  endfunction

  function automatic logic [2:0] pick_vkind();
    int r;
    r = $urandom_range(0, 11);
    if (r < 3) return VK_DIGITAL;
    if (r < 6) return VK_REL;
    if (r < 8) return VK_PULSE;
    if (r < 11) return VK_ABS;
    return 3'($urandom);
  endfunction

  // Q16.16 values: extremes, values around the threshold and anything at all.
  function automatic logic signed [31:0] pick_q();
    logic signed [31:0] near;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return Q_ONE;
      2: return VAL_MAX;
      3: return VAL_MIN;
      4, 5: return 32'(int'($urandom_range(0, 131072)) - 65536);
      6: begin
        near = thresh_now + 32'($urandom_range(0, 2)) - 32'd1;
        return ($urandom_range(0, 1) != 0) ? near : -near;
      end
      default: return $urandom;
    endcase
  endfunction

  // Presents one word from a falling edge and holds it until it is taken.
  task automatic send_word(input event_word_t w);
    int gap;
    @(negedge clk);
    if (!steady && !sender_quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push             <= 1'b1;
    in_cmd           <= w.cmd;
    in_control_index <= w.ctl;
    in_device_slot   <= w.slot;
    in_event_kind    <= w.ek;
    in_event_value   <= w.val;
    in_value_kind    <= w.vk;
    in_device_class  <= w.dc;
    in_platform_code <= w.plat;
    in_seed_present  <= w.sp;
    in_seed_down     <= w.sd;
    do @(posedge clk); while (full);
    words_sent++;
  endtask

  // Drains the block completely, then writes both registers.
  task automatic settle_and_configure(input logic [31:0] thresh, input logic [3:0] mouse);
    @(negedge clk);
    push <= 1'b0;
    wait (outstanding == 0);
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_THRESHOLD;
    cfg_wdata <= thresh;
    @(negedge clk);
    cfg_index <= CFG_MOUSE;
    cfg_wdata <= CFG_DATA_W'(mouse);
    @(negedge clk);
    cfg_we     <= 1'b0;
    thresh_now = thresh;
    mouse_now  = mouse;
  endtask

  // A frame: a few seeds, a run of events mostly from one source, then mostly a resolve.
  task automatic send_frame();
    logic [3:0]  main_dc;
    logic [3:0]  main_plat;
    event_word_t w;
    int          n;
    main_dc   = ($urandom_range(0, 4) == 0) ? mouse_now : 4'($urandom_range(1, 4));
    main_plat = 4'($urandom_range(1, 3));
    n = $urandom_range(0, 2);
    repeat (n) begin
      w     = noise_word();
      w.cmd = CMD_SEED;
      w.ctl = pick_control();
      w.vk  = pick_vkind();
      w.val = pick_q();
      send_word(w);
    end
    n = $urandom_range(1, 6);
    repeat (n) begin
      w     = noise_word();
      w.cmd = CMD_EVENT;
      w.ctl = pick_control();
      w.ek  = pick_ekind();
      w.vk  = pick_vkind();
      w.val = pick_q();
      if ($urandom_range(0, 3) != 0) begin
        w.dc   = main_dc;
        w.plat = main_plat;
      end
      send_word(w);
    end
    // Now and then the activity is left to run into the next frame.
    if ($urandom_range(0, 5) != 0) begin
      w     = noise_word();
      w.cmd = CMD_RESOLVE;
      send_word(w);
    end
  endtask

  logic [31:0] phase_thresh [6];
  logic [3:0]  phase_mouse  [6];
  int          target;

  initial begin
    phase_thresh = '{32'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'($urandom_range(0, 131072)),
                     THRESH_RST, $urandom};
    phase_mouse  = '{4'd0, 4'd15, 4'd3, 4'($urandom), MOUSE_RST, 4'($urandom)};

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed words under the reset settings.
    settle_and_configure(THRESH_RST, MOUSE_RST);
    send_word(mk(CMD_SEED, 8'd0, 2'd0, EV_PRESS, VAL_MAX, VK_DIGITAL, 4'd1, 4'd1, 1'b1, 1'b1));
    send_word(mk(CMD_SEED, 8'd255, 2'd3, EV_PRESS, VAL_MIN, VK_ABS, 4'd1, 4'd1, 1'b1, 1'b1));
    send_word(mk(CMD_SEED, 8'd1, 2'd1, EV_PRESS, Q_ONE, VK_NONE, 4'd1, 4'd1, 1'b1, 1'b1));
    send_word(mk(CMD_SEED, 8'd2, 2'd2, EV_PRESS, Q_ONE, VK_UNKNOWN, 4'd1, 4'd1, 1'b1, 1'b1));
    // A press from one source, then a release that does not rank.
    send_word(mk(CMD_EVENT, 8'd0, 2'd0, EV_PRESS, 32'sd5, VK_DIGITAL, 4'd1, 4'd1, 1'b0, 1'b0));
    send_word(mk(CMD_EVENT, 8'd0, 2'd0, EV_RELEASE, 32'sd7, VK_DIGITAL, 4'd1, 4'd1, 1'b0,
                 1'b0));
    // An axis at the most negative value loses to the momentary rank.
    send_word(mk(CMD_EVENT, 8'd255, 2'd3, EV_ABS, VAL_MIN, VK_ABS, 4'd4, 4'd2, 1'b0, 1'b0));
    // Equal rank from another source: a conflict, and saturation upwards and downwards.
    send_word(mk(CMD_EVENT, 8'd3, 2'd0, EV_REL, VAL_MAX, VK_REL, 4'd3, 4'd2, 1'b0, 1'b0));
    send_word(mk(CMD_EVENT, 8'd3, 2'd0, EV_REL, VAL_MAX, VK_REL, 4'd3, 4'd2, 1'b0, 1'b0));
    send_word(mk(CMD_EVENT, 8'd4, 2'd1, EV_REL, VAL_MIN, VK_REL, 4'd3, 4'd2, 1'b0, 1'b0));
    send_word(mk(CMD_EVENT, 8'd4, 2'd1, EV_REL, VAL_MIN, VK_REL, 4'd3, 4'd2, 1'b0, 1'b0));
    // Mouse motion, a zero pulse and a class of none never rank.
    send_word(mk(CMD_EVENT, 8'd5, 2'd0, EV_REL, Q_ONE, VK_REL, MOUSE_RST, 4'd3, 1'b0, 1'b0));
    send_word(mk(CMD_EVENT, 8'd6, 2'd0, EV_EXIT, 32'sd0, VK_PULSE, 4'd1, 4'd1, 1'b0, 1'b0));
    send_word(mk(CMD_EVENT, 8'd6, 2'd1, EV_EXIT, Q_ONE, VK_PULSE, 4'd0, 4'd5, 1'b0, 1'b0));
    // Unknown event kind, unknown value kind and unknown command.
    send_word(mk(CMD_EVENT, 8'd0, 2'd0, EV_UNKNOWN, Q_ONE, VK_ABS, 4'd6, 4'd6, 1'b0, 1'b0));
    send_word(mk(CMD_EVENT, 8'd0, 2'd1, EV_ABS, Q_ONE, VK_UNKNOWN, 4'd6, 4'd6, 1'b0, 1'b0));
    send_word(mk(CMD_UNUSED, 8'd0, 2'd0, EV_PRESS, Q_ONE, VK_DIGITAL, 4'd7, 4'd7, 1'b1,
                 1'b1));
    // Resolve with a conflict, then with no activity at all.
    send_word(mk(CMD_RESOLVE, 8'd0, 2'd0, EV_PRESS, 32'sd0, VK_NONE, 4'd0, 4'd0, 1'b0, 1'b0));
    send_word(mk(CMD_RESOLVE, 8'd3, 2'd0, EV_PRESS, 32'sd0, VK_NONE, 4'd0, 4'd0, 1'b0, 1'b0));
    // Axis exactly at the threshold, then just beyond it.
    send_word(mk(CMD_EVENT, 8'd7, 2'd3, EV_ABS, 32'sd16384, VK_ABS, 4'd5, 4'd7, 1'b0, 1'b0));
    send_word(mk(CMD_EVENT, 8'd7, 2'd3, EV_ABS, -32'sd16385, VK_ABS, 4'd5, 4'd7, 1'b0, 1'b0));
    // A press on a relative axis outranks the axis and is adopted.
    send_word(mk(CMD_EVENT, 8'd7, 2'd2, EV_PRESS, 32'sd1, VK_REL, 4'd8, 4'd9, 1'b0, 1'b0));
    send_word(mk(CMD_RESOLVE, 8'd7, 2'd2, EV_PRESS, 32'sd0, VK_NONE, 4'd0, 4'd0, 1'b0, 1'b0));
    send_word(mk(CMD_EVENT, 8'd255, 2'd3, EV_RELEASE, VAL_MIN, VK_DIGITAL, 4'd9, 4'd9, 1'b0,
                 1'b0));

    // Random frames under a series of register settings; the last runs without idling.
    for (int p = 0; p < 6; p++) begin
      settle_and_configure(phase_thresh[p], phase_mouse[p]);
      steady = (p == 5);
      target = words_sent + PHASE_WORDS;
      while (words_sent < target) begin
        sender_quiet = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 7) == 0) send_word(noise_word());
        else send_frame();
      end
    end

    @(negedge clk);
    push <= 1'b0;
    wait (outstanding == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
